FILE: rtl/core/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// shared types, codes and tables of the character lcd nibble writer
// ----------------------------------------------------------------------------
package lcdnw_pkg;

	// request kinds
	typedef enum logic [2:0] {
		KIND_INIT    = 3'd0,
		KIND_COMMAND = 3'd1,
		KIND_DATA    = 3'd2,
		KIND_ADDRESS = 3'd3,
		KIND_CURSOR  = 3'd4
	} lcdnw_kind_t;

	// wait classes
	localparam logic [1:0] WAIT_NONE  = 2'd0;
	localparam logic [1:0] WAIT_START = 2'd1;
	localparam logic [1:0] WAIT_SYNC  = 2'd2;
	localparam logic [1:0] WAIT_LONG  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_FUNCTION_SET    = 2'd0;
	localparam logic [1:0] CFG_ENTRY_MODE      = 2'd1;
	localparam logic [1:0] CFG_DISPLAY_CONTROL = 2'd2;

	localparam logic [7:0] FUNCTION_SET_RESET    = 8'b0010_1000;
	localparam logic [7:0] ENTRY_MODE_RESET      = 8'b0000_0110;
	localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'b0000_1100;
	localparam logic [7:0] CMD_CLEAR             = 8'b0000_0001;
	localparam logic [7:0] CMD_SET_ADDRESS       = 8'h80;
	localparam logic [3:0] NIBBLE_WAKE           = 4'h3;
	localparam logic [3:0] NIBBLE_FOUR_BIT       = 4'h2;
	localparam logic [7:0] LONG_CMD_LOW          = 8'h01;
	localparam logic [7:0] LONG_CMD_HIGH         = 8'h03;

	// init sequence: four wake nibbles, then four bytes
	localparam logic [3:0] INIT_LAST_STEP = 4'd11;
	localparam logic [3:0] BYTE_LAST_STEP = 4'd1;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_value;
		logic [2:0] line_number;
		logic [5:0] column_number;
	} lcdnw_in_t;

	typedef struct packed {
		logic       register_select;
		logic [3:0] data_nibble;
		logic [1:0] wait_class;
		logic       last_transfer;
	} lcdnw_out_t;

	typedef struct packed {
		logic [7:0] function_set;
		logic [7:0] entry_mode;
		logic [7:0] display_control;
	} lcdnw_cfg_t;

	// one queued job for the nibble sequencer
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] value;
		logic       long_check;
	} lcdnw_job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} lcdnw_q_status_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RUN  = 1'b1
	} lcdnw_back_state_t;

	// start address of display lines 1 to 4
	function automatic logic [6:0] line_base(input logic [1:0] line_idx);
		logic [6:0] base;
		unique case (line_idx)
			2'd0:    base = 7'h00;
			2'd1:    base = 7'h40;
			2'd2:    base = 7'h14;
			default: base = 7'h54;
		endcase
		return base;
	endfunction

endpackage

FILE: rtl/core/char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// turns display requests into 4-bit bus nibble transfers
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  request   start / busy               cmd    (lcdnw_in_t)
//  transfer  result_valid (strobe)      result (lcdnw_out_t)
//  config    cfg_write                  cfg_index, cfg_data
//
// a request is taken at a clock edge with start high and busy low; the
// sequencer puts out one transfer per cycle; a byte request makes two transfers
// and initialize twelve; when the sequencer is free, a request passes the job
// queue, the job register and the result register before its first transfer
// appears; the job queue absorbs bursts, busy rises when it is full
// reset clears the queue and sequencer and loads the default config bytes
// results cannot be held off: each stays on the ports for one cycle only
//
module char_lcd_nibble_writer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lcdnw_pkg::lcdnw_in_t  cmd,
	output logic                  result_valid,
	output lcdnw_pkg::lcdnw_out_t result,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	lcdnw_pkg::lcdnw_cfg_t      cfg_q;
	lcdnw_pkg::lcdnw_job_t      new_job;
	lcdnw_pkg::lcdnw_job_t      head_job;
	lcdnw_pkg::lcdnw_q_status_t q_status;
	logic                       new_job_valid;
	logic                       accept;
	logic                       push;
	logic                       pop;

	// request is taken only while the queue has room
	assign busy   = q_status.full;
	assign accept = start && !busy;
	// requests that send nothing are taken and dropped here
	assign push   = accept && new_job_valid;

	// configuration bytes used by initialize
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.function_set    <= lcdnw_pkg::FUNCTION_SET_RESET;
			cfg_q.entry_mode      <= lcdnw_pkg::ENTRY_MODE_RESET;
			cfg_q.display_control <= lcdnw_pkg::DISPLAY_CONTROL_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lcdnw_pkg::CFG_FUNCTION_SET:    cfg_q.function_set    <= cfg_data;
				lcdnw_pkg::CFG_ENTRY_MODE:      cfg_q.entry_mode      <= cfg_data;
				lcdnw_pkg::CFG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify the request
	lcdnw_front u_front (
		.cmd       (cmd),
		.job_valid (new_job_valid),
		.job       (new_job)
	);

	// job queue
	lcdnw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (new_job),
		.pop       (pop),
		.pop_data  (head_job),
		.status    (q_status)
	);

	// back: nibble sequencer with registered result
	lcdnw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.head         (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	// transfers of one request come in consecutive cycles
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_transfer |=> result_valid)
		else $error("transfer burst broken before its last nibble");

	// the start wait only comes with the first wake nibble
	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.wait_class == lcdnw_pkg::WAIT_START
		|-> result.data_nibble == lcdnw_pkg::NIBBLE_WAKE && !result.register_select
		&& !result.last_transfer)
		else $error("start wait on a wrong transfer");

	// a long wait is only asked for after a command nibble
	a_long_cmd_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.wait_class == lcdnw_pkg::WAIT_LONG
		|-> !result.register_select)
		else $error("long wait on a data transfer");

	// the queue never takes a job while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full && !pop |=> q_status.full)
		else $error("job queue lost an entry");
`endif

endmodule

FILE: rtl/core/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// classifies a request into a sequencer job, or drops it
// ----------------------------------------------------------------------------
module lcdnw_front (
	input  lcdnw_pkg::lcdnw_in_t  cmd,
	output logic                  job_valid,
	output lcdnw_pkg::lcdnw_job_t job
);

	logic [6:0] cursor_addr;
	logic       cursor_ok;

	// base plus column minus one, wraps at 128
	assign cursor_addr = lcdnw_pkg::line_base(2'(cmd.line_number - 3'd1))
		+ {1'b0, cmd.column_number} - 7'd1;
	assign cursor_ok = (cmd.line_number >= 3'd1) && (cmd.line_number <= 3'd4)
		&& (cmd.column_number != 6'd0);

	always_comb begin
		job_valid      = 1'b0;
		job.is_init    = 1'b0;
		job.rs         = 1'b0;
		job.value      = cmd.byte_value;
		job.long_check = 1'b0;
		unique case (cmd.kind)
			lcdnw_pkg::KIND_INIT: begin
				job_valid      = 1'b1;
				job.is_init    = 1'b1;
				job.long_check = 1'b1;
			end
			lcdnw_pkg::KIND_COMMAND: begin
				job_valid      = 1'b1;
				job.long_check = 1'b1;
			end
			lcdnw_pkg::KIND_DATA: begin
				job_valid = 1'b1;
				job.rs    = 1'b1;
			end
			lcdnw_pkg::KIND_ADDRESS: begin
				job_valid = 1'b1;
				job.value = lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, cmd.byte_value[6:0]};
			end
			lcdnw_pkg::KIND_CURSOR: begin
				job_valid = cursor_ok;
				job.value = lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, cursor_addr};
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/lcdnw_fifo.sv
// ----------------------------------------------------------------------------
// lcdnw_fifo
// short job queue between classifier and sequencer
// ----------------------------------------------------------------------------
module lcdnw_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  lcdnw_pkg::lcdnw_job_t     push_data,
	input  logic                      pop,
	output lcdnw_pkg::lcdnw_job_t     pop_data,
	output lcdnw_pkg::lcdnw_q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	lcdnw_pkg::lcdnw_job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

FILE: rtl/core/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// nibble sequencer: one transfer per cycle from the queued job
// ----------------------------------------------------------------------------
module lcdnw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lcdnw_pkg::lcdnw_cfg_t      cfg,
	input  lcdnw_pkg::lcdnw_q_status_t q_status,
	input  lcdnw_pkg::lcdnw_job_t      head,
	output logic                       pop,
	output logic                       result_valid,
	output lcdnw_pkg::lcdnw_out_t      result
);

	lcdnw_pkg::lcdnw_back_state_t state_q;
	lcdnw_pkg::lcdnw_back_state_t state_next;
	lcdnw_pkg::lcdnw_job_t        job_q;
	logic [3:0]                   step_q;
	logic [3:0]                   init_off;
	logic                         last_now;
	logic                         running;
	logic [7:0]                   cur_byte;
	lcdnw_pkg::lcdnw_out_t        xfer;
	logic                         result_valid_q;
	lcdnw_pkg::lcdnw_out_t        result_q;

	assign init_off = step_q - 4'd4;
	assign last_now = job_q.is_init ? (step_q == lcdnw_pkg::INIT_LAST_STEP)
		: (step_q == lcdnw_pkg::BYTE_LAST_STEP);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lcdnw_pkg::BK_IDLE: begin
				if (!q_status.empty) state_next = lcdnw_pkg::BK_RUN;
			end
			lcdnw_pkg::BK_RUN: begin
				if (last_now && q_status.empty) state_next = lcdnw_pkg::BK_IDLE;
			end
			default: state_next = lcdnw_pkg::BK_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		running = 1'b0;
		pop     = 1'b0;
		unique case (state_q)
			lcdnw_pkg::BK_IDLE: begin
				pop = !q_status.empty;
			end
			lcdnw_pkg::BK_RUN: begin
				running = 1'b1;
				pop     = last_now && !q_status.empty;
			end
			default: begin
				running = 1'b0;
			end
		endcase
	end

	// byte being sent at this step
	always_comb begin
		cur_byte = job_q.value;
		if (job_q.is_init) begin
			unique case (init_off[2:1])
				2'd0:    cur_byte = cfg.function_set;
				2'd1:    cur_byte = cfg.entry_mode;
				2'd2:    cur_byte = cfg.display_control;
				default: cur_byte = lcdnw_pkg::CMD_CLEAR;
			endcase
		end
	end

	always_comb begin
		xfer.register_select = job_q.rs;
		xfer.last_transfer   = last_now;
		xfer.wait_class      = lcdnw_pkg::WAIT_NONE;
		if (step_q[0]) begin
			xfer.data_nibble = cur_byte[3:0];
			if (job_q.long_check && cur_byte >= lcdnw_pkg::LONG_CMD_LOW
				&& cur_byte <= lcdnw_pkg::LONG_CMD_HIGH) begin
				xfer.wait_class = lcdnw_pkg::WAIT_LONG;
			end
		end else begin
			xfer.data_nibble = cur_byte[7:4];
		end
		// wake-up nibbles of init
		if (job_q.is_init && step_q < 4'd4) begin
			unique case (step_q[1:0])
				2'd0: begin
					xfer.data_nibble = lcdnw_pkg::NIBBLE_WAKE;
					xfer.wait_class  = lcdnw_pkg::WAIT_START;
				end
				2'd1, 2'd2: begin
					xfer.data_nibble = lcdnw_pkg::NIBBLE_WAKE;
					xfer.wait_class  = lcdnw_pkg::WAIT_SYNC;
				end
				default: begin
					xfer.data_nibble = lcdnw_pkg::NIBBLE_FOUR_BIT;
					xfer.wait_class  = lcdnw_pkg::WAIT_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lcdnw_pkg::BK_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_next;
			result_valid_q <= running;
			if (pop) begin
				step_q <= '0;
			end else if (running) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		result_q <= xfer;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: sim/char_lcd_nibble_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_test
// self-checking bench for the character lcd nibble writer
// ----------------------------------------------------------------------------
// drives display requests on the start / busy port and predicts, for every
// request taken, the nibble transfers it must cause; every strobed transfer
// is checked field by field against the oldest prediction. directed cases
// cover byte extremes, clear / home long waits, address masking, cursor line
// bases and wrap, bad cursors and unused kinds; random phases follow with
// changing register settings and different amounts of sender idling
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_test;
	import lcdnw_pkg::*;

	localparam int          HALF_PERIOD    = 6;
	localparam int          RESET_CYCLES   = 10;
	localparam int          MAX_GAP        = 40;
	localparam int          DRAIN_LIMIT    = 20000;
	localparam int          SETTLE_CYCLES  = 64;
	localparam int          PHASE_ITEMS    = 100;
	// kinds the block has no use for
	localparam logic [2:0]  KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0]  KIND_UNUSED_LAST  = 3'd7;
	// register index with no register behind it
	localparam logic [1:0]  CFG_NO_REGISTER   = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	lcdnw_in_t  cmd;
	logic       result_valid;
	lcdnw_out_t result;
	logic       cfg_write;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// predicted transfers, oldest first
	lcdnw_out_t pending_transfers[$];
	// the bench's own copy of the three init command bytes
	lcdnw_cfg_t cfg_shadow;

	int sender_idle_pct;
	int requests_taken;
	int transfers_seen;
	int register_writes;
	int error_count;

	char_lcd_nibble_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// transfer prediction
	// ------------------------------------------------------------------

	// one nibble pulse, never the last one here; the caller marks that
	function automatic void add_nibble(logic rs, logic [3:0] nib, logic [1:0] wclass);
		lcdnw_out_t t;
		t.register_select = rs;
		t.data_nibble     = nib;
		t.wait_class      = wclass;
		t.last_transfer   = 1'b0;
		pending_transfers.push_back(t);
	endfunction

	// a byte goes out high nibble first; clear and home get a long wait
	// after the low nibble when the caller asks for that check
	function automatic int add_byte(logic rs, logic [7:0] b, bit long_check);
		logic [1:0] low_wait;
		low_wait = WAIT_NONE;
		if (long_check && b >= LONG_CMD_LOW && b <= LONG_CMD_HIGH)
			low_wait = WAIT_LONG;
		add_nibble(rs, b[7:4], WAIT_NONE);
		add_nibble(rs, b[3:0], low_wait);
		return 2;
	endfunction

	// works out every transfer one request causes and queues them in bus order
	function automatic void predict_transfers(lcdnw_in_t req);
		int         n;
		logic [7:0] base;
		logic [7:0] addr;
		lcdnw_out_t tail;
		n = 0;
		case (req.kind)
			KIND_INIT: begin
				// power-up wake sequence, then the configured bytes and a clear
				add_nibble(1'b0, NIBBLE_WAKE, WAIT_START);
				add_nibble(1'b0, NIBBLE_WAKE, WAIT_SYNC);
				add_nibble(1'b0, NIBBLE_WAKE, WAIT_SYNC);
				add_nibble(1'b0, NIBBLE_FOUR_BIT, WAIT_NONE);
				n = 4;
				n += add_byte(1'b0, cfg_shadow.function_set, 1'b1);
				n += add_byte(1'b0, cfg_shadow.entry_mode, 1'b1);
				n += add_byte(1'b0, cfg_shadow.display_control, 1'b1);
				n += add_byte(1'b0, CMD_CLEAR, 1'b1);
			end
			KIND_COMMAND: n = add_byte(1'b0, req.byte_value, 1'b1);
			KIND_DATA:    n = add_byte(1'b1, req.byte_value, 1'b0);
			KIND_ADDRESS: n = add_byte(1'b0, CMD_SET_ADDRESS | {1'b0, req.byte_value[6:0]}, 1'b0);
			KIND_CURSOR: begin
				// lines 1 to 4 only, columns count from 1
				if (req.line_number >= 3'd1 && req.line_number <= 3'd4 &&
				    req.column_number != 6'd0) begin
					case (req.line_number)
						3'd1:    base = 8'h00;
						3'd2:    base = 8'h40;
						3'd3:    base = 8'h14;
						default: base = 8'h54;
					endcase
					// address wraps at 128
					addr = (base + {2'b00, req.column_number} - 8'd1) & 8'h7f;
					n = add_byte(1'b0, CMD_SET_ADDRESS | addr, 1'b0);
				end
			end
			default: ; // unused kinds cause nothing
		endcase
		if (n > 0) begin
			tail = pending_transfers.pop_back();
			tail.last_transfer = 1'b1;
			pending_transfers.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// transfer checking
	// ------------------------------------------------------------------

	function automatic void report_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// results are strobes: sample at every edge, nothing holds them
	always @(posedge clk) begin
		lcdnw_out_t want;
		if (result_valid === 1'b1) begin
			transfers_seen++;
			if (pending_transfers.size() == 0) begin
				error_count++;
				$display("%0t: transfer with nothing expected, expected none actual %h",
					$time, result);
			end else begin
				want = pending_transfers.pop_front();
				report_field("register_select", {3'b000, want.register_select},
					{3'b000, result.register_select});
				report_field("data_nibble", want.data_nibble, result.data_nibble);
				report_field("wait_class", {2'b00, want.wait_class}, {2'b00, result.wait_class});
				report_field("last_transfer", {3'b000, want.last_transfer},
					{3'b000, result.last_transfer});
			end
		end
	end

	// ------------------------------------------------------------------
	// shared drivers
	// ------------------------------------------------------------------

	// hold one item on cmd until the block takes it, then maybe idle a while
	task automatic send_item(input lcdnw_in_t req);
		int gap;
		start <= 1'b1;
		cmd   <= req;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		requests_taken++;
		predict_transfers(req);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop requesting, let every predicted transfer arrive, then let the block
	// settle; requests that cause no transfer never reach the sequencer
	task automatic wait_for_drain;
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_transfers.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only ever called with the block idle
	task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_FUNCTION_SET:    cfg_shadow.function_set    = val;
			CFG_ENTRY_MODE:      cfg_shadow.entry_mode      = val;
			CFG_DISPLAY_CONTROL: cfg_shadow.display_control = val;
			default: ; // no register there
		endcase
		register_writes++;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic lcdnw_in_t make_request(logic [2:0] kind, logic [7:0] bval,
			logic [2:0] line, logic [5:0] col);
		lcdnw_in_t req;
		req.kind          = kind;
		req.byte_value    = bval;
		req.line_number   = line;
		req.column_number = col;
		return req;
	endfunction

	// mostly well-formed requests with random content, some noise
	function automatic lcdnw_in_t make_random_request;
		lcdnw_in_t req;
		int        pick;
		req  = make_request(KIND_COMMAND, 8'($urandom_range(0, 255)),
			3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
		pick = $urandom_range(0, 99);
		if (pick < 6)
			req.kind = KIND_INIT;
		else if (pick < 30) begin
			req.kind = KIND_COMMAND;
			// clear and home often, for the long wait
			if ($urandom_range(0, 4) == 0)
				req.byte_value = 8'($urandom_range(LONG_CMD_LOW, LONG_CMD_HIGH));
		end else if (pick < 58)
			req.kind = KIND_DATA;
		else if (pick < 73)
			req.kind = KIND_ADDRESS;
		else if (pick < 94) begin
			req.kind = KIND_CURSOR;
			if ($urandom_range(0, 99) < 85)
				req.line_number = 3'($urandom_range(1, 4));
			if ($urandom_range(0, 99) < 90)
				req.column_number = 6'($urandom_range(1, 63));
		end else
			req.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		return req;
	endfunction

	// extremes, clear / home values and plain random bytes
	function automatic logic [7:0] pick_config_byte;
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hff;
			2:       return 8'($urandom_range(LONG_CMD_LOW, LONG_CMD_HIGH));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// init with the registers as reset left them
	task automatic test_reset_defaults;
		send_item(make_request(KIND_INIT, 8'h00, 3'd0, 6'd0));
		wait_for_drain();
	endtask

	// one request of each kind at the edges of its fields
	task automatic test_directed_requests;
		logic [2:0] k;
		// command extremes and the three long-wait values around them
		send_item(make_request(KIND_COMMAND, 8'h00, 3'd7, 6'd63));
		send_item(make_request(KIND_COMMAND, 8'h01, 3'd0, 6'd0));
		send_item(make_request(KIND_COMMAND, 8'h02, 3'd0, 6'd0));
		send_item(make_request(KIND_COMMAND, 8'h03, 3'd0, 6'd0));
		send_item(make_request(KIND_COMMAND, 8'h04, 3'd0, 6'd0));
		send_item(make_request(KIND_COMMAND, 8'hff, 3'd0, 6'd0));
		// data never gets a long wait, even for clear-like values
		send_item(make_request(KIND_DATA, 8'h00, 3'd0, 6'd0));
		send_item(make_request(KIND_DATA, 8'hff, 3'd7, 6'd63));
		send_item(make_request(KIND_DATA, 8'h02, 3'd0, 6'd0));
		// set address drops bit 7 of the byte
		send_item(make_request(KIND_ADDRESS, 8'h00, 3'd0, 6'd0));
		send_item(make_request(KIND_ADDRESS, 8'h7f, 3'd0, 6'd0));
		send_item(make_request(KIND_ADDRESS, 8'h80, 3'd0, 6'd0));
		send_item(make_request(KIND_ADDRESS, 8'hff, 3'd0, 6'd0));
		// each line base, and line 4 far enough out to wrap the address
		send_item(make_request(KIND_CURSOR, 8'hff, 3'd1, 6'd1));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd2, 6'd20));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd3, 6'd1));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd4, 6'd63));
		// bad line or column zero: nothing goes out
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd0, 6'd5));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd5, 6'd5));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd7, 6'd63));
		send_item(make_request(KIND_CURSOR, 8'h00, 3'd2, 6'd0));
		// unused kinds cause nothing either
		for (k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST && k >= KIND_UNUSED_FIRST; k++)
			send_item(make_request(k, 8'hff, 3'd1, 6'd1));
		wait_for_drain();
	endtask

	// configured bytes at the extremes and at clear / home values
	task automatic test_config_extremes;
		write_register(CFG_FUNCTION_SET, 8'h00);
		write_register(CFG_ENTRY_MODE, 8'hff);
		write_register(CFG_DISPLAY_CONTROL, 8'h01);
		send_item(make_request(KIND_INIT, 8'hff, 3'd7, 6'd63));
		wait_for_drain();
		write_register(CFG_FUNCTION_SET, 8'h02);
		write_register(CFG_ENTRY_MODE, 8'h03);
		write_register(CFG_DISPLAY_CONTROL, 8'hff);
		// a write to the empty index must leave all three alone
		write_register(CFG_NO_REGISTER, 8'ha5);
		send_item(make_request(KIND_INIT, 8'h00, 3'd0, 6'd0));
		wait_for_drain();
	endtask

	// new settings, then a burst of random requests at one idle rate
	task automatic test_random_phase(input int idle_pct);
		write_register(CFG_FUNCTION_SET, pick_config_byte());
		write_register(CFG_ENTRY_MODE, pick_config_byte());
		write_register(CFG_DISPLAY_CONTROL, pick_config_byte());
		sender_idle_pct = idle_pct;
		repeat (PHASE_ITEMS) send_item(make_random_request());
		wait_for_drain();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		cfg_write       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sender_idle_pct = 0;
		requests_taken  = 0;
		transfers_seen  = 0;
		register_writes = 0;
		error_count     = 0;
		cfg_shadow.function_set    = FUNCTION_SET_RESET;
		cfg_shadow.entry_mode      = ENTRY_MODE_RESET;
		cfg_shadow.display_control = DISPLAY_CONTROL_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_requests();
		test_config_extremes();
		// back to the reset values before the random part
		write_register(CFG_FUNCTION_SET, FUNCTION_SET_RESET);
		write_register(CFG_ENTRY_MODE, ENTRY_MODE_RESET);
		write_register(CFG_DISPLAY_CONTROL, DISPLAY_CONTROL_RESET);
		test_random_phase(0);
		test_random_phase(74);
		test_random_phase(6);

		// predictions that never showed up
		if (pending_transfers.size() != 0) begin
			error_count++;
			$display("%0t: transfers missing, expected %0d more actual 0",
				$time, pending_transfers.size());
		end

		$display("summary: %0d requests taken, %0d nibble transfers checked, %0d register writes",
			requests_taken, transfers_seen, register_writes);
		$display("covered all kinds, bad cursors, config extremes, sender idle 0/74/6 percent");
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#5_000_000;
		$display("timeout at %0t", $time);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_front.sv
rtl/core/lcdnw_fifo.sv
rtl/core/lcdnw_back.sv
rtl/core/char_lcd_nibble_writer.sv
sim/char_lcd_nibble_writer_test.sv
